// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, types and pointer helpers of the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

  // store geometry
  localparam int DEPTH   = 256;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int CNT_FIELD_W = 9;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 3;

  localparam logic signed [WORD_W-1:0] NEG_ONE = -32'sd1;

  // action codes
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_NOP        = 3'd4
  } action_t;

  // one result word
  typedef struct packed {
    logic signed [WORD_W-1:0]      popped_value;
    logic                          pop_found;
    logic [CNT_FIELD_W-1:0]        entry_count;
    logic                          is_empty;
    logic signed [WORD_W-1:0]      front_value;
    logic signed [WORD_W-1:0]      back_value;
    logic                          overflow;
  } result_t;

  // engine status toward the stream wrapper
  typedef struct packed {
    logic busy;
    logic res_valid;
  } eng_status_t;

  // circular pointer step forward
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // circular pointer step back
  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  // count folded into the result field, low bits kept
  function automatic logic [CNT_FIELD_W-1:0] count_field(input logic [COUNT_W-1:0] c);
    logic [COUNT_W+CNT_FIELD_W-1:0] ext;
    ext = (COUNT_W + CNT_FIELD_W)'(c);
    return ext[CNT_FIELD_W-1:0];
  endfunction

endpackage

// File: sv/double_ended_queue_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit words in a 256-entry circular store
// ----------------------------------------------------------------------------
// Each input word carries an action (push front, push back, pop front, pop
// back, no operation) and a value; each gives exactly one result word with
// the popped value, count, empty flag, front and back words and an overflow
// flag. Pushes, no-ops and pops that leave the queue empty or hit an empty
// queue finish in the step that takes them; a pop that leaves words behind
// waits for the new front or back word, fetched through the store's single
// registered read port. Results sit in an output register; the next word
// is taken when that register is empty or in the same cycle its result
// leaves, and not while a refill read is still in flight.
module double_ended_queue_core (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dq_pkg::IN_TDATA_W-1:0]       s_tdata,  // [31:0] push_value
  input  logic [dq_pkg::IN_TUSER_W-1:0]       s_tuser,  // [2:0] action
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] popped_value, [40:32] entry_count, [72:41] front_value,
  // [104:73] back_value, [111:105] zero
  output logic [dq_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // [0] pop_found, [1] is_empty, [2] overflow
  output logic [dq_pkg::OUT_TUSER_W-1:0]      m_tuser
);
  import dq_pkg::*;

  eng_status_t status;
  result_t     res;
  result_t     out_res;
  logic        start;

  // accept when no refill is pending and the output slot frees up
  assign s_tready = !status.busy && (!m_tvalid || m_tready);
  assign start    = s_tvalid && s_tready;

  dq_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action_t'(s_tuser[2:0])),
    .push_value (s_tdata[WORD_W-1:0]),
    .status     (status),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status.res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (status.res_valid) begin
      out_res <= res;
    end
  end

  // pack result word
  assign m_tdata = {7'd0, out_res.back_value, out_res.front_value,
                    out_res.entry_count, out_res.popped_value};
  assign m_tuser = {out_res.overflow, out_res.is_empty, out_res.pop_found};

  // checks
  `ASSERT_IMPL(a_refill_slot_free, clk, rst, status.busy, !m_tvalid)
  `ASSERT_NEXT(a_refill_one_cycle, clk, rst, status.busy, !status.busy)
  `ASSERT_IMPL(a_pop_push_exclusive, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[2]))

endmodule

// File: sv/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/dq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_engine
// Pointer, count and end-word state of the queue around the word store
// ----------------------------------------------------------------------------
module dq_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  dq_pkg::action_t                     action,
  input  logic signed [dq_pkg::WORD_W-1:0]    push_value,
  output dq_pkg::eng_status_t                 status,
  output dq_pkg::result_t                     res
);
  import dq_pkg::*;

  // architectural state
  logic [PTR_W-1:0]          head, head_next;
  logic [PTR_W-1:0]          tail, tail_next;
  logic [COUNT_W-1:0]        count, count_next;
  logic signed [WORD_W-1:0]  front, front_next;
  logic signed [WORD_W-1:0]  back, back_next;

  // refill of an end word after a pop
  logic                      pend, pend_next;
  logic                      pend_front, pend_front_next;
  logic signed [WORD_W-1:0]  popped_q, popped_q_next;

  // store ports
  logic                      wr_en;
  logic [PTR_W-1:0]          wr_addr;
  logic                      rd_en;
  logic [PTR_W-1:0]          rd_addr;
  logic [WORD_W-1:0]         rd_data;

  // step results
  logic signed [WORD_W-1:0]  popped_c;
  logic                      found_c;
  logic                      ovf_c;
  logic                      need_rd;
  logic                      full;

  assign full = (count == COUNT_W'(DEPTH));

  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state of one step
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    front_next      = front;
    back_next       = back;
    pend_next       = 1'b0;
    pend_front_next = pend_front;
    popped_q_next   = popped_q;
    wr_en           = 1'b0;
    wr_addr         = head;
    rd_en           = 1'b0;
    rd_addr         = head;
    popped_c        = NEG_ONE;
    found_c         = 1'b0;
    ovf_c           = 1'b0;
    need_rd         = 1'b0;
    if (pend) begin
      // new end word arrives from the store
      if (pend_front) begin
        front_next = rd_data;
      end else begin
        back_next = rd_data;
      end
      popped_c = popped_q;
      found_c  = 1'b1;
    end else if (start) begin
      unique case (action)
        ACT_PUSH_FRONT: begin
          if (full) begin
            ovf_c = 1'b1;
          end else begin
            head_next  = ptr_dec(head);
            wr_en      = 1'b1;
            wr_addr    = ptr_dec(head);
            front_next = push_value;
            if (count == '0) begin
              tail_next = ptr_dec(head);
              back_next = push_value;
            end
            count_next = count + COUNT_W'(1);
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            ovf_c = 1'b1;
          end else begin
            wr_en = 1'b1;
            if (count == '0) begin
              wr_addr    = head;
              tail_next  = head;
              front_next = push_value;
            end else begin
              wr_addr   = ptr_inc(tail);
              tail_next = ptr_inc(tail);
            end
            back_next  = push_value;
            count_next = count + COUNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (count != '0) begin
            popped_c   = front;
            found_c    = 1'b1;
            head_next  = ptr_inc(head);
            count_next = count - COUNT_W'(1);
            if (count > COUNT_W'(1)) begin
              rd_en           = 1'b1;
              rd_addr         = ptr_inc(head);
              need_rd         = 1'b1;
              pend_next       = 1'b1;
              pend_front_next = 1'b1;
              popped_q_next   = front;
            end
          end
        end
        ACT_POP_BACK: begin
          if (count != '0) begin
            popped_c   = back;
            found_c    = 1'b1;
            tail_next  = ptr_dec(tail);
            count_next = count - COUNT_W'(1);
            if (count > COUNT_W'(1)) begin
              rd_en           = 1'b1;
              rd_addr         = ptr_dec(tail);
              need_rd         = 1'b1;
              pend_next       = 1'b1;
              pend_front_next = 1'b0;
              popped_q_next   = back;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      pend  <= pend_next;
    end
    front      <= front_next;
    back       <= back_next;
    pend_front <= pend_front_next;
    popped_q   <= popped_q_next;
  end

  // result of the step, ends masked when empty
  always_comb begin
    res.popped_value = popped_c;
    res.pop_found    = found_c;
    res.entry_count  = count_field(count_next);
    res.is_empty     = (count_next == '0);
    res.front_value  = (count_next == '0) ? NEG_ONE : front_next;
    res.back_value   = (count_next == '0) ? NEG_ONE : back_next;
    res.overflow     = ovf_c;
  end

  assign status.busy      = pend;
  assign status.res_valid = pend || (start && !need_rd);

endmodule

// File: tb/tb_double_ended_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core
// Self-checking bench for the 256-entry double-ended queue core
// ----------------------------------------------------------------------------
// Commands go in on the input stream and a tracker keeps its own copy of the
// queue to work out each expected result word. Result words are compared
// field by field against the tracker in arrival order. The run starts with a
// directed pass over empty-queue pops, unused actions and extreme values. It
// then runs random segments that fill the store to overflow, drain it past
// empty and mix actions. Three idle/stall profiles are applied in turn.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_core;
  import dq_pkg::*;

  // tracks queue contents and checks each result word in order
  class deque_tracker;
    logic [WORD_W-1:0]  word_mem [DEPTH];
    logic [PTR_W-1:0]   head;
    logic [COUNT_W-1:0] fill;
    result_t            expected_results [$];
    int                 errors;

    function new();
      head   = '0;
      fill   = '0;
      errors = 0;
    endfunction

    function logic [PTR_W-1:0] slot(input int offset);
      return PTR_W'((int'(head) + offset) % DEPTH);
    endfunction

    // apply one command and queue the result word it should produce
    function void note_command(input logic [2:0] act, input logic [WORD_W-1:0] val);
      result_t r;
      logic    full;
      full           = (fill >= COUNT_W'(DEPTH));
      r              = '0;
      r.popped_value = NEG_ONE;
      case (act)
        ACT_PUSH_FRONT: begin
          if (full) begin
            r.overflow = 1'b1;
          end else begin
            head           = slot(DEPTH - 1);
            word_mem[head] = val;
            fill           = fill + COUNT_W'(1);
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            r.overflow = 1'b1;
          end else begin
            word_mem[slot(int'(fill))] = val;
            fill                       = fill + COUNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (fill != 0) begin
            r.popped_value = word_mem[head];
            r.pop_found    = 1'b1;
            head           = slot(1);
            fill           = fill - COUNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (fill != 0) begin
            r.popped_value = word_mem[slot(int'(fill) - 1)];
            r.pop_found    = 1'b1;
            fill           = fill - COUNT_W'(1);
          end
        end
        default: ;
      endcase
      r.entry_count = CNT_FIELD_W'(fill);
      r.is_empty    = (fill == 0);
      r.front_value = (fill != 0) ? word_mem[head] : NEG_ONE;
      r.back_value  = (fill != 0) ? word_mem[slot(int'(fill) - 1)] : NEG_ONE;
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void compare_field(input string name, input logic [WORD_W-1:0] exp_v,
                                input logic [WORD_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    // compare one result word against the oldest expectation
    function void check_result(input logic [OUT_TDATA_W-1:0] data,
                               input logic [OUT_TUSER_W-1:0] user);
      result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual %h / %h",
                 $time, data, user);
        return;
      end
      e = expected_results[0];
      expected_results.delete(0);
      compare_field("popped_value", e.popped_value, data[31:0]);
      compare_field("entry_count", WORD_W'(e.entry_count), WORD_W'(data[40:32]));
      compare_field("front_value", e.front_value, data[72:41]);
      compare_field("back_value", e.back_value, data[104:73]);
      compare_field("pop_found", WORD_W'(e.pop_found), WORD_W'(user[0]));
      compare_field("is_empty", WORD_W'(e.is_empty), WORD_W'(user[1]));
      compare_field("overflow", WORD_W'(e.overflow), WORD_W'(user[2]));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  deque_tracker tracker = new();
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  double_ended_queue_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_result(m_tdata, m_tuser);
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // present one command word and hold it until taken
  task automatic send_command(input logic [2:0] act, input logic [WORD_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    tracker.note_command(act, val);
    @(negedge clk);
  endtask

  // hold off the sender until every result word is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
  endfunction

  function automatic logic [2:0] pick_pop();
    return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  // one of the three unused action codes
  function automatic logic [2:0] pick_unused();
    return ACT_NOP + 3'($urandom_range(3, 1));
  endfunction

  // random segments for one idle profile
  task automatic run_phase(input int budget, input int forced);
    int sent;
    int seg_len;
    int kind;
    int r;
    logic [2:0] act;
    sent = 0;
    // fill to full and push into it a few more times
    if (forced == 1) begin
      while (tracker.fill < COUNT_W'(DEPTH)) begin
        send_command(pick_push(), pick_value());
        sent++;
      end
      repeat ($urandom_range(4, 2)) begin
        send_command(pick_push(), pick_value());
        sent++;
      end
    end
    // drain to empty and pop past it
    if (forced == 2) begin
      while (tracker.fill != 0) begin
        send_command(pick_pop(), pick_value());
        sent++;
      end
      repeat ($urandom_range(3, 2)) begin
        send_command(pick_pop(), pick_value());
        sent++;
      end
    end
    while (sent < budget) begin
      kind    = $urandom_range(2);
      seg_len = $urandom_range(60, 10);
      repeat (seg_len) begin
        r = $urandom_range(99);
        case (kind)
          0:       act = (r < 85) ? pick_push() : pick_pop();
          1:       act = (r < 85) ? pick_pop() : pick_push();
          default: act = (r < 35) ? pick_push() : (r < 75) ? pick_pop() :
                         (r < 90) ? ACT_NOP : pick_unused();
        endcase
        send_command(act, pick_value());
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pops, unused actions, extreme values, every action
    send_command(ACT_POP_FRONT, 32'h1234_5678);
    send_command(ACT_POP_BACK, 32'h8765_4321);
    send_command(ACT_NOP, 32'hFFFF_FFFF);
    send_command(ACT_NOP + 3'd1, 32'h0000_0000);
    send_command(ACT_NOP + 3'd2, 32'hFFFF_FFFF);
    send_command(ACT_NOP + 3'd3, 32'hA5A5_A5A5);
    send_command(ACT_PUSH_BACK, 32'h7FFF_FFFF);
    send_command(ACT_PUSH_FRONT, 32'h8000_0000);
    send_command(ACT_PUSH_BACK, 32'h0000_0000);
    send_command(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_command(ACT_NOP, 32'h5555_5555);
    send_command(ACT_POP_BACK, 32'h0);
    send_command(ACT_POP_FRONT, 32'h0);
    send_command(ACT_PUSH_BACK, 32'h5555_5555);
    send_command(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
    send_command(ACT_NOP + 3'd3, 32'h0);
    send_command(ACT_POP_FRONT, 32'h0);
    send_command(ACT_POP_BACK, 32'h0);
    send_command(ACT_POP_BACK, 32'h0);
    send_command(ACT_POP_FRONT, 32'h0);
    send_command(ACT_PUSH_FRONT, 32'h0000_0001);
    send_command(ACT_POP_BACK, 32'h0);
    wait_drained();

    // sender idles lightly, receiver stalls heavily
    send_idle_pct  = 16;
    recv_stall_pct = 53;
    run_phase(400, 1);

    // swapped profile
    send_idle_pct  = 53;
    recv_stall_pct = 16;
    run_phase(400, 2);

    // full rate both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(400, 1);

    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_engine.sv
sv/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
